// ===== design/mbc_pkg.sv =====
package mbc_pkg;

  localparam int LUX_W = 24;
  localparam int LEVEL_W = 16;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_ADJUST = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    mode_t              mode;
    logic [LUX_W-1:0]   lux;
    logic [LEVEL_W-1:0] level;
    logic [5:0]         index;
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SAMP,
    ST_DIV,
    ST_SAMP_DONE,
    ST_ADJ_LO,
    ST_ADJ_HI,
    ST_ADJ_TRIM,
    ST_ERASE,
    ST_INS_CHK,
    ST_SHIFT,
    ST_INS,
    ST_DONE
  } state_t;

endpackage

// ===== design/mbc_front.sv =====
// Front part: accepts beats, packs them into requests and holds them in a
// two-entry queue for the back part.
module mbc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  output logic                  ready,
  input  logic [1:0]            mode,
  input  logic [23:0]           lux,
  input  logic [15:0]           brightness,
  input  logic [3:0]            point_index,
  output logic                  req_valid,
  input  logic                  req_ready,
  output mbc_pkg::req_t         req
);
  import mbc_pkg::*;

  req_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign ready     = (fill != 2'd2);
  assign req_valid = (fill != 2'd0);
  assign req       = slot[rd_ptr];
  assign push      = valid && ready;
  assign pop       = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{mode: mode_t'(mode), lux: lux, level: brightness,
                        index: {2'b00, point_index}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/mbc_div.sv =====
// Restoring divider, one quotient bit per cycle. Quotient is truncated.
module mbc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [23:0] divisor,
  output logic        busy,
  output logic [39:0] quotient
);
  logic [5:0]  count;
  logic [24:0] rem;
  logic [24:0] trial;
  logic [23:0] dvs;

  assign trial = {rem[23:0], quotient[39]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 6'd40;
    end else if (busy) begin
      count <= count - 6'd1;
      if (count == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (!trial[24]) begin
        rem      <= trial;
        quotient <= {quotient[38:0], 1'b1};
      end else begin
        rem      <= {rem[23:0], quotient[39]};
        quotient <= {quotient[38:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/mbc_back.sv =====
// Back part: owns the point table and carries out one request at a time.
module mbc_back #(
  parameter int MAX_POINTS = 16,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  mbc_pkg::req_t        req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          sampled_brightness,
  output logic [23:0]          read_lux,
  output logic [15:0]          read_brightness,
  output logic                 index_valid,
  output logic [4:0]           point_total,
  output logic                 overflow
);
  import mbc_pkg::*;

  logic [LUX_W-1:0]   tab_lux   [MAX_POINTS];
  logic [LEVEL_W-1:0] tab_level [MAX_POINTS];
  logic [CW-1:0]      count;

  state_t state, state_next;
  req_t   cur;
  logic [CW-1:0] lo, hi, ptr, pos;
  logic [IW-1:0] pi, pim1;
  logic [LEVEL_W-1:0] b0, b1;
  logic [LUX_W-1:0]   l0;
  logic [LEVEL_W-1:0] r_samp;
  logic               ovf;

  logic        div_start, div_busy;
  logic [39:0] div_q;
  logic [39:0] dividend;
  logic [23:0] divisor;
  logic [23:0] off;
  logic [15:0] delta;

  // ptr indexes the table; entries beyond MAX_POINTS are never read.
  assign pi   = ptr[IW-1:0];
  assign pim1 = IW'(ptr - CW'(1));

  mbc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend),
    .divisor(divisor), .busy(div_busy), .quotient(div_q)
  );

  assign req_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE:      if (req_valid && req_ready) begin
                      unique case (req.mode)
                        MODE_SAMPLE, MODE_ADJUST: state_next = ST_SCAN;
                        default: state_next = ST_DONE;
                      endcase
                    end
      ST_SCAN:      if (!(ptr < count && tab_lux[pi] < cur.lux)) begin
                      state_next = (cur.mode == MODE_SAMPLE) ? ST_SAMP : ST_ADJ_LO;
                    end
      ST_SAMP:      if (ptr == '0 || ptr >= count || b1 == b0) state_next = ST_DONE;
                    else begin
                      div_start  = 1'b1;
                      state_next = ST_DIV;
                    end
      ST_DIV:       if (!div_busy) state_next = ST_SAMP_DONE;
      ST_SAMP_DONE: state_next = ST_DONE;
      ST_ADJ_LO:    if (!(ptr < count && tab_lux[pi] <= cur.lux)) state_next = ST_ADJ_HI;
      ST_ADJ_HI:    if (!(lo > '0 && tab_level[IW'(lo - CW'(1))] >= cur.level) &&
                        !(hi < count && tab_level[hi[IW-1:0]] <= cur.level))
                      state_next = ST_ADJ_TRIM;
      ST_ADJ_TRIM:  state_next = ST_ERASE;
      ST_ERASE:     if (!(ptr < count)) state_next = ST_INS_CHK;
      ST_INS_CHK:   state_next = ST_SHIFT;
      ST_SHIFT:     if (!(ptr > pos)) state_next = ST_INS;
      ST_INS:       state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Interpolation operands.
  assign off      = cur.lux - l0;
  assign delta    = (b1 >= b0) ? (b1 - b0) : (b0 - b1);
  assign dividend = 40'(delta) * 40'(off);
  assign divisor  = (tab_lux[pi] > l0) ? (tab_lux[pi] - l0) : 24'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      count     <= CW'(1);
      tab_lux[0]   <= '0;
      tab_level[0] <= FULL_LEVEL;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (req_valid && req_ready) begin
          cur    <= req;
          ptr    <= '0;
          r_samp <= '0;
          ovf    <= 1'b0;
        end
        ST_SCAN: begin
          if (ptr < count && tab_lux[pi] < cur.lux) ptr <= ptr + CW'(1);
          else begin
            lo <= ptr;
            b1 <= tab_level[pi];
            b0 <= tab_level[pim1];
            l0 <= tab_lux[pim1];
          end
        end
        ST_SAMP: begin
          if (ptr == '0) r_samp <= tab_level[0];
          else if (ptr >= count) r_samp <= tab_level[IW'(count - CW'(1))];
          else r_samp <= b0;
        end
        ST_DIV: ;
        ST_SAMP_DONE: begin
          if (b1 >= b0) r_samp <= b0 + div_q[15:0];
          else r_samp <= b0 - div_q[15:0];
        end
        ST_ADJ_LO: begin
          if (ptr < count && tab_lux[pi] <= cur.lux) ptr <= ptr + CW'(1);
          else hi <= ptr;
        end
        ST_ADJ_HI: begin
          if (lo > '0 && tab_level[IW'(lo - CW'(1))] >= cur.level) lo <= lo - CW'(1);
          if (hi < count && tab_level[hi[IW-1:0]] <= cur.level) hi <= hi + CW'(1);
        end
        ST_ADJ_TRIM: begin
          // Keep range ends that already carry the new brightness.
          logic [CW-1:0] l2, h2;
          l2 = lo;
          h2 = hi;
          if (l2 != h2 && tab_level[l2[IW-1:0]] == cur.level &&
              tab_lux[l2[IW-1:0]] < cur.lux) l2 = l2 + CW'(1);
          if (h2 != l2 && tab_level[IW'(h2 - CW'(1))] == cur.level &&
              tab_lux[IW'(h2 - CW'(1))] > cur.lux) h2 = h2 - CW'(1);
          lo  <= l2;
          hi  <= h2;
          ptr <= h2;
          pos <= l2;
        end
        ST_ERASE: begin
          if (ptr < count) begin
            tab_lux[IW'(pos + (ptr - hi))]   <= tab_lux[pi];
            tab_level[IW'(pos + (ptr - hi))] <= tab_level[pi];
            ptr <= ptr + CW'(1);
          end else begin
            count <= count - (hi - lo);
          end
        end
        ST_INS_CHK: begin
          if (!(pos == '0 || pos == count ||
                tab_level[IW'(pos - CW'(1))] != tab_level[pos[IW-1:0]])) begin
            ptr <= '0;
            pos <= '0;
            hi  <= '0;
          end else if (count >= CW'(MAX_POINTS)) begin
            ovf <= 1'b1;
            ptr <= '0;
            pos <= '0;
            hi  <= '0;
          end else begin
            ptr <= count;
            hi  <= CW'(1);
          end
        end
        ST_SHIFT: begin
          if (ptr > pos) begin
            tab_lux[pi]   <= tab_lux[pim1];
            tab_level[pi] <= tab_level[pim1];
            ptr <= ptr - CW'(1);
          end
        end
        ST_INS: begin
          if (hi == CW'(1)) begin
            tab_lux[pos[IW-1:0]]   <= cur.lux;
            tab_level[pos[IW-1:0]] <= cur.level;
            count <= count + CW'(1);
          end
        end
        ST_DONE: begin
          out_valid          <= 1'b1;
          sampled_brightness <= (cur.mode == MODE_SAMPLE) ? r_samp : '0;
          overflow           <= ovf;
          point_total        <= 5'(count);
          if (cur.mode == MODE_READ && cur.index < 6'(count)) begin
            index_valid     <= 1'b1;
            read_lux        <= tab_lux[cur.index[IW-1:0]];
            read_brightness <= tab_level[cur.index[IW-1:0]];
          end else begin
            index_valid     <= 1'b0;
            read_lux        <= '0;
            read_brightness <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/monotone_brightness_curve_unit.sv =====
// Monotone brightness curve unit.
// Input channel (valid/ready) carries one request beat: mode, lux,
// brightness and point_index. Mode 0 samples the curve, mode 1 adjusts it
// with a user point, mode 2 reads a stored point, mode 3 does nothing.
// Output channel (out_valid/out_ready) returns exactly one result beat per
// request, in order.
// A read or no-op goes straight to the result. A sample first scans the points
// below the input lux; when it interpolates it then waits on the 40-step
// divider and adds the quotient. An adjust runs the scans, range search,
// erase and shift.
// The serial divider and the single table walker set the rate: one request
// is worked on at a time, and the next one is taken in the cycle after the
// result beat has left.
// A two-beat queue at the front keeps taking requests while the back works or
// while a finished result waits; when the receiver stalls the result is held
// and the queue fills, then ready drops.
// Reset empties the queue and leaves one point: lux 0 at full brightness.
module monotone_brightness_curve_unit #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [23:0] lux,
  input  logic [15:0] brightness,
  input  logic [3:0]  point_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] sampled_brightness,
  output logic [23:0] read_lux,
  output logic [15:0] read_brightness,
  output logic        index_valid,
  output logic [4:0]  point_total,
  output logic        overflow
);
  import mbc_pkg::*;

  // Table index width and count width follow from the table depth.
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1) + 1;

  req_t req;
  logic req_valid;
  logic req_ready;

  mbc_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready),
    .mode(mode), .lux(lux), .brightness(brightness), .point_index(point_index),
    .req_valid(req_valid), .req_ready(req_ready), .req(req)
  );

  mbc_back #(.MAX_POINTS(MAX_POINTS), .IW(IW), .CW(CW)) u_back (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .req(req), .out_valid(out_valid), .out_ready(out_ready),
    .sampled_brightness(sampled_brightness), .read_lux(read_lux),
    .read_brightness(read_brightness), .index_valid(index_valid),
    .point_total(point_total), .overflow(overflow)
  );

endmodule
